/* design/vcd_pkg.sv */
// ----------------------------------------------------------------------------
// vcd_pkg: shared types and constants for the VOR course-deviation block
// Holds the CORDIC pipeline word, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package vcd_pkg;

  localparam int CW        = 64;
  localparam int POS_W     = 32;
  localparam int DIFF_W    = 33;
  localparam int ACC_W     = 32;
  localparam int COURSE_W  = 16;
  localparam int DEV_W     = 16;
  localparam int TAB_DEPTH = 24;
  localparam int SCALE_SH  = 26;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_STATION_X       = 2'd0;
  localparam logic [IDX_W-1:0] REG_STATION_Z       = 2'd1;
  localparam logic [IDX_W-1:0] REG_SELECTED_COURSE = 2'd2;

  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
    logic [ACC_W-1:0]     acc;
  } cordic_t;

  // atan(2^-i), 2^32 counts per turn
  function automatic logic [ACC_W-1:0] atan_entry(input int i);
    logic [ACC_W-1:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/vcd_front.sv */
// ----------------------------------------------------------------------------
// vcd_front: station-relative vector and CORDIC pre-rotation
// Two register stages: the position difference, then scaling and the
// half-turn pre-rotation that brings the vector into the right half plane.
// ----------------------------------------------------------------------------
module vcd_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [vcd_pkg::POS_W-1:0]      aircraft_x,
  input  logic signed [vcd_pkg::POS_W-1:0]      aircraft_z,
  input  logic signed [vcd_pkg::POS_W-1:0]      station_x,
  input  logic signed [vcd_pkg::POS_W-1:0]      station_z,
  output vcd_pkg::cordic_t                      out
);

  logic                                 diff_valid;
  logic signed [vcd_pkg::DIFF_W-1:0]    dx;
  logic signed [vcd_pkg::DIFF_W-1:0]    dz;
  logic signed [vcd_pkg::CW-1:0]        sx;
  logic signed [vcd_pkg::CW-1:0]        sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else begin
      diff_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dx <= {station_x[vcd_pkg::POS_W-1], station_x} - {aircraft_x[vcd_pkg::POS_W-1], aircraft_x};
    dz <= {station_z[vcd_pkg::POS_W-1], station_z} - {aircraft_z[vcd_pkg::POS_W-1], aircraft_z};
  end

  assign sx = {{(vcd_pkg::CW - vcd_pkg::DIFF_W - vcd_pkg::SCALE_SH){dx[vcd_pkg::DIFF_W-1]}},
               dx, {vcd_pkg::SCALE_SH{1'b0}}};
  assign sz = {{(vcd_pkg::CW - vcd_pkg::DIFF_W - vcd_pkg::SCALE_SH){dz[vcd_pkg::DIFF_W-1]}},
               dz, {vcd_pkg::SCALE_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    out.zero <= (dx == '0) && (dz == '0);
    if (dz[vcd_pkg::DIFF_W-1]) begin
      out.re  <= -sz;
      out.im  <= -sx;
      out.acc <= vcd_pkg::HALF_TURN;
    end else begin
      out.re  <= sz;
      out.im  <= sx;
      out.acc <= '0;
    end
  end

endmodule

/* design/vcd_cordic_stage.sv */
// ----------------------------------------------------------------------------
// vcd_cordic_stage: one registered CORDIC vectoring iteration
// Rotates toward the positive real axis by atan(2^-IDX) and accumulates
// the bearing.
// ----------------------------------------------------------------------------
module vcd_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  vcd_pkg::cordic_t in,
  output vcd_pkg::cordic_t out
);

  localparam logic [vcd_pkg::ACC_W-1:0] ANG = vcd_pkg::atan_entry(IDX);

  logic signed [vcd_pkg::CW-1:0] sre;
  logic signed [vcd_pkg::CW-1:0] sim;

  assign sre = in.re >>> IDX;
  assign sim = in.im >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out.zero <= in.zero;
    if (in.im > 0) begin
      out.re  <= in.re + sim;
      out.im  <= in.im - sre;
      out.acc <= in.acc + ANG;
    end else begin
      out.re  <= in.re - sim;
      out.im  <= in.im + sre;
      out.acc <= in.acc - ANG;
    end
  end

endmodule

/* design/vcd_back.sv */
// ----------------------------------------------------------------------------
// vcd_back: course difference, TO/FROM and folded deviation
// Two register stages: bearing rounding, course subtraction and folding,
// then conversion to 65536 counts per turn and sign.
// ----------------------------------------------------------------------------
module vcd_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vcd_pkg::cordic_t                     in,
  input  logic [vcd_pkg::COURSE_W-1:0]         selected_course,
  output logic                                 done,
  output logic                                 to_flag,
  output logic signed [vcd_pkg::DEV_W-1:0]     course_deviation
);

  localparam int A     = ANGLE_BITS;
  localparam int CXW   = vcd_pkg::COURSE_W + A;
  localparam int SUMW  = A + 17;
  localparam logic [vcd_pkg::ACC_W-1:0] RND = vcd_pkg::ACC_W'(1) << (31 - A);
  localparam logic [A-1:0] QUARTER = A'(1) << (A - 2);
  localparam logic [A-1:0] HALF    = A'(1) << (A - 1);
  localparam logic [A-1:0] THREEQ  = QUARTER + HALF;
  localparam logic [SUMW-1:0] MRND = SUMW'(1) << (A - 1);

  logic [vcd_pkg::ACC_W-1:0] acc_r;
  logic [A-1:0]              b;
  logic [CXW-1:0]            cx;
  logic [A-1:0]              c;
  logic [A-1:0]              d;
  logic [A-2:0]              e;
  logic [A-2:0]              mag_next;

  logic                      v1;
  logic                      zero1;
  logic                      to1;
  logic                      neg1;
  logic [A-2:0]              mag;
  logic [SUMW-1:0]           msum;
  logic [vcd_pkg::DEV_W-1:0] mag16;

  assign acc_r    = in.acc + RND;
  assign b        = acc_r[vcd_pkg::ACC_W-1 -: A];
  assign cx       = {selected_course, {A{1'b0}}};
  assign c        = cx[CXW-1 -: A];
  assign d        = b - c;
  assign e        = d[A-2:0];
  assign mag_next = ({1'b0, e} <= QUARTER) ? e : (A-1)'(HALF - {1'b0, e});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in.valid;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    zero1 <= in.zero;
    to1   <= (d < QUARTER) || (d > THREEQ);
    neg1  <= d > HALF;
    mag   <= mag_next;
  end

  assign msum  = SUMW'({mag, 16'b0}) + MRND;
  assign mag16 = msum[A+15 : A];

  always_ff @(posedge clk) begin
    if (zero1) begin
      to_flag          <= 1'b0;
      course_deviation <= 16'sd16384;
    end else begin
      to_flag          <= to1;
      course_deviation <= neg1 ? -$signed(mag16) : $signed(mag16);
    end
  end

endmodule

/* design/vor_course_deviation.sv */
// ----------------------------------------------------------------------------
// vor_course_deviation: VOR course-deviation indicator pipeline
// Bearing to the station by pipelined CORDIC atan2, compared against the
// selected course to give TO/FROM and a signed deviation.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   request  | start / busy     | aircraft_x, aircraft_z
//   result   | done (strobe)    | to_flag, course_deviation
//   config   | cfg_write        | cfg_index, cfg_data
//
// One request per cycle; busy stays low. Each result passes through two
// front stages, min(CORDIC_STAGES,24) CORDIC stages of one iteration each,
// and two back stages.
// Synchronous reset clears the valid pipeline and the station/course
// registers. The result strobe lasts one cycle and is never held off.
// ----------------------------------------------------------------------------
module vor_course_deviation #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vcd_pkg::POS_W-1:0]      aircraft_x,
  input  logic signed [vcd_pkg::POS_W-1:0]      aircraft_z,
  output logic                                  done,
  output logic                                  to_flag,
  output logic signed [vcd_pkg::DEV_W-1:0]      course_deviation,
  input  logic                                  cfg_write,
  input  logic [vcd_pkg::IDX_W-1:0]             cfg_index,
  input  logic [vcd_pkg::POS_W-1:0]             cfg_data
);

  localparam int NS = (CORDIC_STAGES < vcd_pkg::TAB_DEPTH) ? CORDIC_STAGES
                                                            : vcd_pkg::TAB_DEPTH;

  logic signed [vcd_pkg::POS_W-1:0]  station_x;
  logic signed [vcd_pkg::POS_W-1:0]  station_z;
  logic [vcd_pkg::COURSE_W-1:0]      selected_course;
  vcd_pkg::cordic_t                  pipe [0:NS];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_x       <= '0;
      station_z       <= '0;
      selected_course <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        vcd_pkg::REG_STATION_X:       station_x       <= cfg_data;
        vcd_pkg::REG_STATION_Z:       station_z       <= cfg_data;
        vcd_pkg::REG_SELECTED_COURSE: selected_course <= cfg_data[vcd_pkg::COURSE_W-1:0];
        default: ;
      endcase
    end
  end

  vcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .aircraft_x (aircraft_x),
    .aircraft_z (aircraft_z),
    .station_x  (station_x),
    .station_z  (station_z),
    .out        (pipe[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    vcd_cordic_stage #(
      .IDX (g)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .in  (pipe[g]),
      .out (pipe[g+1])
    );
  end

  vcd_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .in               (pipe[NS]),
    .selected_course  (selected_course),
    .done             (done),
    .to_flag          (to_flag),
    .course_deviation (course_deviation)
  );

endmodule
